>>> src/mmp_pkg.sv
// Package for the modular matrix power block: sizes, modulus constants, request types.
package mmp_pkg;

  localparam int unsigned MAX_DIM = 8;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned CELLS   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned VAL_W   = 30;
  localparam int unsigned EXP_W   = 31;
  localparam int unsigned DIM_W   = 4;

  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
  // Barrett constant floor(2^60 / p)
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODULUS));

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POWER = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [EXP_W-1:0] exponent;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [VAL_W-1:0] out_value;
    logic             last;
  } out_rsp_t;

endpackage

>>> src/modular_matrix_power.sv
// Top level: stored matrix raised to a power modulo 1000000007, one shared multiply-reduce unit.
//
//  channel | ports                         | direction | notes
//  --------+-------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_data   | in        | write entry or power request
//  out     | out_valid, out_ready, out_data| out       | n*n entries, last on final
//  cfg     | cfg_we, cfg_wdata             | in        | dim register, no wait
//
// A write request is taken while idle. A power request with n = active dim loads the
// identity and the stored matrix (read, write per entry), then forms each product term
// by term through the one Barrett multiply-reduce unit (read, multiply, quotient, q*p,
// reduce, accumulate) and copies it from scratch. Per exponent bit it multiplies by the
// base if the bit is set and squares the base while bits remain, then emits the entries
// (read, load, wait). in_ready is high only when the sequencer is idle. The result
// stage holds its entry while out_ready is low. rst_n is synchronous; stored entries
// read as zero after reset through per-entry valid bits, no clearing pass.
module modular_matrix_power (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mmp_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mmp_pkg::out_rsp_t             out_data,
  input  logic                          cfg_we,
  input  logic [mmp_pkg::DIM_W-1:0]     cfg_wdata
);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_INIT_RD  = 15'b000000000000010,
    ST_INIT_WR  = 15'b000000000000100,
    ST_CHECK    = 15'b000000000001000,
    ST_M_RD     = 15'b000000000010000,
    ST_M_MUL    = 15'b000000000100000,
    ST_M_Q      = 15'b000000001000000,
    ST_M_QP     = 15'b000000010000000,
    ST_M_RED    = 15'b000000100000000,
    ST_M_ACC    = 15'b000001000000000,
    ST_CP_RD    = 15'b000010000000000,
    ST_CP_WR    = 15'b000100000000000,
    ST_OUT_RD   = 15'b001000000000000,
    ST_OUT_LD   = 15'b010000000000000,
    ST_OUT_WAIT = 15'b100000000000000
  } state_t;

  localparam int unsigned IW = mmp_pkg::IDX_W;
  localparam int unsigned AW = mmp_pkg::ADDR_W;
  localparam int unsigned VW = mmp_pkg::VAL_W;

  state_t                       state_r, state_nxt;
  logic [mmp_pkg::DIM_W-1:0]    dim_r, dim_nxt;
  logic [IW-1:0]                n_m1_r, n_m1_nxt;
  logic [mmp_pkg::EXP_W-1:0]    exp_r, exp_nxt;
  logic                         sq_r, sq_nxt;      // 1: base squared, 0: acc times base
  logic [IW-1:0]                i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [2*VW-1:0]              prod_r, prod_nxt;
  logic [30:0]                  q3_r, q3_nxt;
  logic [31:0]                  qp_r, qp_nxt;
  logic [VW-1:0]                red_r, red_nxt;
  logic [VW-1:0]                acc_r, acc_nxt;
  logic [mmp_pkg::CELLS-1:0]    s_vld_r, s_vld_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mmp_pkg::out_rsp_t            out_data_r, out_data_nxt;

  // RAM ports
  logic          s_we, a_we, b_we, p_we;
  logic [AW-1:0] s_waddr;
  logic [VW-1:0] s_wdata, a_wdata, b_wdata, p_wdata;
  logic [AW-1:0] addr_ij, addr_ik, addr_kj, a_raddr;
  logic [VW-1:0] s_rdata, a_rdata, b_rdata_a, b_rdata_b, p_rdata;

  // datapath helpers
  logic          in_acc;
  logic [VW-1:0] opa;
  logic [61:0]   q_full;
  logic [31:0]   qp_lo, r_raw, r_one;
  logic [VW:0]   acc_sum;
  logic [VW-1:0] acc_red;
  logic          j_last, i_last, k_last;
  logic [IW-1:0] j_adv, i_adv;
  logic [mmp_pkg::DIM_W-1:0] n_act;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign addr_ij = {i_r, j_r};
  assign addr_ik = {i_r, k_r};
  assign addr_kj = {k_r, j_r};
  assign a_raddr = (state_r == ST_M_RD) ? addr_ik : addr_ij;

  // active dim: 0 acts as 1, above MAX_DIM acts as MAX_DIM
  always_comb begin
    if (dim_r == '0) begin
      n_act = mmp_pkg::DIM_W'(1);
    end else if (dim_r > mmp_pkg::DIM_W'(mmp_pkg::MAX_DIM)) begin
      n_act = mmp_pkg::DIM_W'(mmp_pkg::MAX_DIM);
    end else begin
      n_act = dim_r;
    end
  end

  // row-major walk over the n x n region
  assign j_last = (j_r == n_m1_r);
  assign i_last = (i_r == n_m1_r);
  assign k_last = (k_r == n_m1_r);
  assign j_adv  = j_last ? '0 : j_r + IW'(1);
  assign i_adv  = j_last ? (i_last ? '0 : i_r + IW'(1)) : i_r;

  // write data reduce: value < 2^30 < 2p
  assign s_waddr = {in_data.row, in_data.col};
  assign s_wdata = (in_data.value >= mmp_pkg::MODULUS) ?
                   in_data.value - mmp_pkg::MODULUS : in_data.value;
  assign s_we    = in_acc && (in_data.command == mmp_pkg::CMD_WRITE);

  // Barrett reduction of prod_r, spread over M_Q / M_QP / M_RED
  assign opa    = sq_r ? b_rdata_a : a_rdata;
  assign q_full = {31'b0, prod_r[59:29]} * {31'b0, mmp_pkg::BARRETT_MU};
  assign qp_lo  = 32'(q3_r) * 32'(mmp_pkg::MODULUS);
  assign r_raw  = prod_r[31:0] - qp_r;                 // < 3p
  assign r_one  = (r_raw >= 32'(mmp_pkg::MODULUS)) ? r_raw - 32'(mmp_pkg::MODULUS) : r_raw;
  assign acc_sum = {1'b0, acc_r} + {1'b0, red_r};
  assign acc_red = (acc_sum >= (VW+1)'(mmp_pkg::MODULUS)) ?
                   VW'(acc_sum - (VW+1)'(mmp_pkg::MODULUS)) : VW'(acc_sum);

  // RAM write controls
  assign a_we    = (state_r == ST_INIT_WR) || ((state_r == ST_CP_WR) && !sq_r);
  assign b_we    = (state_r == ST_INIT_WR) || ((state_r == ST_CP_WR) && sq_r);
  assign a_wdata = (state_r == ST_INIT_WR) ? VW'(i_r == j_r) : p_rdata;
  assign b_wdata = (state_r == ST_INIT_WR) ?
                   (s_vld_r[addr_ij] ? s_rdata : '0) : p_rdata;
  assign p_we    = (state_r == ST_M_ACC) && k_last;
  assign p_wdata = acc_red;

  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = cfg_we ? cfg_wdata : dim_r;
    n_m1_nxt      = n_m1_r;
    exp_nxt       = exp_r;
    sq_nxt        = sq_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    q3_nxt        = q3_r;
    qp_nxt        = qp_r;
    red_nxt       = red_r;
    acc_nxt       = acc_r;
    s_vld_nxt     = s_vld_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (s_we) begin
          s_vld_nxt[s_waddr] = 1'b1;
        end
        if (in_acc && (in_data.command == mmp_pkg::CMD_POWER)) begin
          n_m1_nxt  = IW'(n_act - mmp_pkg::DIM_W'(1));
          exp_nxt   = in_data.exponent;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_INIT_RD;
        end
      end
      ST_INIT_RD: state_nxt = ST_INIT_WR;
      ST_INIT_WR: begin
        i_nxt     = i_adv;
        j_nxt     = j_adv;
        state_nxt = (j_last && i_last) ? ST_CHECK : ST_INIT_RD;
      end
      ST_CHECK: begin
        k_nxt   = '0;
        acc_nxt = '0;
        if (exp_r == '0) begin
          state_nxt = ST_OUT_RD;
        end else if (exp_r[0]) begin
          exp_nxt   = {exp_r[mmp_pkg::EXP_W-1:1], 1'b0};
          sq_nxt    = 1'b0;
          state_nxt = ST_M_RD;
        end else begin
          exp_nxt = exp_r >> 1;
          sq_nxt  = 1'b1;
          if ((exp_r >> 1) != '0) begin
            state_nxt = ST_M_RD;
          end
        end
      end
      ST_M_RD:  state_nxt = ST_M_MUL;
      ST_M_MUL: begin
        prod_nxt  = {{VW{1'b0}}, opa} * {{VW{1'b0}}, b_rdata_b};
        state_nxt = ST_M_Q;
      end
      ST_M_Q: begin
        q3_nxt    = q_full[61:31];
        state_nxt = ST_M_QP;
      end
      ST_M_QP: begin
        qp_nxt    = qp_lo;
        state_nxt = ST_M_RED;
      end
      ST_M_RED: begin
        red_nxt   = (r_one >= 32'(mmp_pkg::MODULUS)) ?
                    VW'(r_one - 32'(mmp_pkg::MODULUS)) : VW'(r_one);
        state_nxt = ST_M_ACC;
      end
      ST_M_ACC: begin
        if (k_last) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          i_nxt     = i_adv;
          j_nxt     = j_adv;
          state_nxt = (j_last && i_last) ? ST_CP_RD : ST_M_RD;
        end else begin
          k_nxt     = k_r + IW'(1);
          acc_nxt   = acc_red;
          state_nxt = ST_M_RD;
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        i_nxt     = i_adv;
        j_nxt     = j_adv;
        state_nxt = (j_last && i_last) ? ST_CHECK : ST_CP_RD;
      end
      ST_OUT_RD: state_nxt = ST_OUT_LD;
      ST_OUT_LD: begin
        out_data_nxt.out_row   = i_r;
        out_data_nxt.out_col   = j_r;
        out_data_nxt.out_value = a_rdata;
        out_data_nxt.last      = j_last && i_last;
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          i_nxt         = i_adv;
          j_nxt         = j_adv;
          state_nxt     = (j_last && i_last) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_r       <= mmp_pkg::DIM_W'(1);
      s_vld_r     <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      s_vld_r     <= s_vld_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_m1_r     <= n_m1_nxt;
    exp_r      <= exp_nxt;
    sq_r       <= sq_nxt;
    prod_r     <= prod_nxt;
    q3_r       <= q3_nxt;
    qp_r       <= qp_nxt;
    red_r      <= red_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // source matrix
  mmp_ram #(.WIDTH(VW), .DEPTH(mmp_pkg::CELLS)) u_src_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr_a(addr_ij), .rdata_a(s_rdata), .raddr_b(addr_ij), .rdata_b()
  );

  // power accumulator
  mmp_ram #(.WIDTH(VW), .DEPTH(mmp_pkg::CELLS)) u_acc_ram (
    .clk(clk), .we(a_we), .waddr(addr_ij), .wdata(a_wdata),
    .raddr_a(a_raddr), .rdata_a(a_rdata), .raddr_b(addr_ij), .rdata_b()
  );

  // squared base, two read ports for the squaring product
  mmp_ram #(.WIDTH(VW), .DEPTH(mmp_pkg::CELLS)) u_base_ram (
    .clk(clk), .we(b_we), .waddr(addr_ij), .wdata(b_wdata),
    .raddr_a(addr_ik), .rdata_a(b_rdata_a), .raddr_b(addr_kj), .rdata_b(b_rdata_b)
  );

  // product scratch
  mmp_ram #(.WIDTH(VW), .DEPTH(mmp_pkg::CELLS)) u_scr_ram (
    .clk(clk), .we(p_we), .waddr(addr_ij), .wdata(p_wdata),
    .raddr_a(addr_ij), .rdata_a(p_rdata), .raddr_b(addr_ij), .rdata_b()
  );

  a_out_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT_WAIT)
    else $error("result valid outside emit wait");

  a_power_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.command == mmp_pkg::CMD_POWER) |=> state_r == ST_INIT_RD)
    else $error("power request did not start load");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |->
      (out_data.out_row == n_m1_r && out_data.out_col == n_m1_r))
    else $error("last flag off the final entry");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_M_ACC |-> (red_r < mmp_pkg::MODULUS && acc_r < mmp_pkg::MODULUS))
    else $error("reduction left value above modulus");

endmodule

>>> src/mmp_ram.sv
// Generic RAM: one write port, two registered read ports.
module mmp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> bench/tb.sv
// Testbench for modular_matrix_power: predicts matrix powers mod p and checks every entry.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PRIME = 64'd1000000007;
  localparam int unsigned CYCLE_LIMIT = 30_000_000;
  // write requests finish on acceptance; margin before a cfg write or the end
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef longint unsigned mat_t [mmp_pkg::CELLS];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mmp_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mmp_pkg::out_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [mmp_pkg::DIM_W-1:0] cfg_wdata = '0;

  modular_matrix_power DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow state of the block
  mat_t stored_matrix;
  logic [mmp_pkg::DIM_W-1:0] dim_shadow;
  mmp_pkg::out_rsp_t expected_entries[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned failure_count = 0;

  // Sender pacing: bursts of random length, random gaps between them
  bit sender_paced = 1'b1;
  int unsigned burst_left = 0;
  // Receiver pacing
  bit receiver_paced = 1'b1;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  logic [7:0] stall_pattern = 8'hb5;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: long hold-off when asked, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!receiver_paced) begin
      out_ready <= 1'b1;
    end else begin
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if ($urandom_range(0, 63) == 0) stall_pattern = 8'($urandom);
      out_ready <= stall_pattern[0] | (stall_pattern == 8'h00);
    end
  end

  // Result checker: each accepted entry against the oldest expectation
  always @(posedge clk) begin
    mmp_pkg::out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        failure_count++;
        if (mismatch_count < 10)
          $display("unexpected result: row %0d col %0d value %0d last %0b",
                   out_data.out_row, out_data.out_col, out_data.out_value, out_data.last);
        mismatch_count++;
      end else begin
        want = expected_entries.pop_front();
        if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
            out_data.out_value !== want.out_value || out_data.last !== want.last) begin
          failure_count++;
          if (mismatch_count < 10)
            $display("mismatch: exp r%0d c%0d v%0d l%0b, got r%0d c%0d v%0d l%0b",
                     want.out_row, want.out_col, want.out_value, want.last,
                     out_data.out_row, out_data.out_col, out_data.out_value, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned active_size();
    if (dim_shadow == 0) return 1;
    if (dim_shadow > mmp_pkg::MAX_DIM) return mmp_pkg::MAX_DIM;
    return 32'(dim_shadow);
  endfunction

  // Product over the top-left n x n part; each term reduced mod p, each sum at the end
  function automatic mat_t mat_product(mat_t a, mat_t b, int unsigned n);
    mat_t p;
    longint unsigned acc;
    p = a;
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < n; j++) begin
        acc = 0;
        for (int unsigned k = 0; k < n; k++)
          acc += (a[i*mmp_pkg::MAX_DIM+k] * b[k*mmp_pkg::MAX_DIM+j]) % PRIME;
        p[i*mmp_pkg::MAX_DIM+j] = acc % PRIME;
      end
    return p;
  endfunction

  // Square-and-multiply from the identity, then queue the entries row-major
  task automatic predict_power(logic [mmp_pkg::EXP_W-1:0] exponent);
    mat_t acc_m;
    mat_t base_m;
    int unsigned n;
    logic [mmp_pkg::EXP_W-1:0] e;
    mmp_pkg::out_rsp_t entry;
    n = active_size();
    e = exponent;
    acc_m = stored_matrix;
    base_m = stored_matrix;
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < n; j++)
        acc_m[i*mmp_pkg::MAX_DIM+j] = (i == j) ? 64'd1 : 64'd0;
    while (e != 0) begin
      if (e[0]) acc_m = mat_product(acc_m, base_m, n);
      e = e >> 1;
      if (e != 0) base_m = mat_product(base_m, base_m, n);
    end
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < n; j++) begin
        entry.out_row = mmp_pkg::IDX_W'(i);
        entry.out_col = mmp_pkg::IDX_W'(j);
        entry.out_value = mmp_pkg::VAL_W'(acc_m[i*mmp_pkg::MAX_DIM+j]);
        entry.last = (i == n - 1) && (j == n - 1);
        expected_entries = {expected_entries, entry};
      end
  endtask

  // Offer one request, hold it until accepted, then update the prediction
  task automatic send_request(mmp_pkg::in_req_t req);
    int unsigned gap;
    if (sender_paced && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (req.command == mmp_pkg::CMD_WRITE)
      stored_matrix[req.row*mmp_pkg::MAX_DIM+req.col] = longint'(req.value) % PRIME;
    else
      predict_power(req.exponent);
  endtask

  task automatic write_entry(int unsigned r, int unsigned c,
                             logic [mmp_pkg::VAL_W-1:0] v);
    mmp_pkg::in_req_t req;
    req = '0;
    req.command = mmp_pkg::CMD_WRITE;
    req.row = mmp_pkg::IDX_W'(r);
    req.col = mmp_pkg::IDX_W'(c);
    req.value = v;
    req.exponent = mmp_pkg::EXP_W'($urandom);
    send_request(req);
  endtask

  task automatic run_power(logic [mmp_pkg::EXP_W-1:0] exponent);
    mmp_pkg::in_req_t req;
    req.command = mmp_pkg::CMD_POWER;
    req.row = mmp_pkg::IDX_W'($urandom);
    req.col = mmp_pkg::IDX_W'($urandom);
    req.value = mmp_pkg::VAL_W'($urandom);
    req.exponent = exponent;
    send_request(req);
  endtask

  // Stop offering and wait until every expected entry is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dim(logic [mmp_pkg::DIM_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_shadow = d;
  endtask

  function automatic logic [mmp_pkg::VAL_W-1:0] rand_value();
    if ($urandom_range(0, 7) == 0) return mmp_pkg::VAL_W'($urandom);
    return mmp_pkg::VAL_W'($urandom_range(0, 1000000006));
  endfunction

  // Exponent width kept small at large sizes so products stay cheap
  function automatic logic [mmp_pkg::EXP_W-1:0] rand_exponent(int unsigned max_bits);
    int unsigned bits;
    bits = $urandom_range(0, max_bits);
    return mmp_pkg::EXP_W'($urandom & ((32'd1 << bits) - 1));
  endfunction

  // After reset: 1x1 zero matrix, identity for exponent zero
  task automatic test_reset_state();
    run_power('0);
    run_power(mmp_pkg::EXP_W'(5));
    drain();
  endtask

  // Extremes of every field, dim clamping, unreduced values, large exponents
  task automatic test_directed();
    set_dim(4'd2);
    write_entry(0, 0, 30'd1000000006);
    write_entry(0, 1, 30'h3fffffff);
    write_entry(1, 0, 30'd1000000007);
    write_entry(1, 1, 30'd0);
    write_entry(7, 7, 30'd123456789);
    write_entry(7, 0, 30'd1000000006);
    run_power('0);
    run_power(mmp_pkg::EXP_W'(1));
    run_power({mmp_pkg::EXP_W{1'b1}});
    drain();
    set_dim(4'd0);
    run_power(mmp_pkg::EXP_W'(3));
    drain();
    set_dim(4'd15);
    write_entry(0, 7, 30'd2);
    write_entry(3, 5, 30'd999999999);
    run_power(mmp_pkg::EXP_W'(2));
    drain();
    set_dim(4'd8);
    for (int unsigned k = 0; k < 8; k++) write_entry(k, 7 - k, rand_value());
    run_power({mmp_pkg::EXP_W{1'b1}});
    drain();
  endtask

  // Random phases over all dim codes; writes dominate so powers see fresh data
  task automatic test_random(int unsigned item_total);
    int unsigned sent;
    int unsigned n;
    int unsigned max_bits;
    sent = 0;
    while (sent < item_total) begin
      set_dim(mmp_pkg::DIM_W'($urandom_range(0, 15)));
      n = active_size();
      max_bits = (n <= 2) ? 31 : (n <= 4) ? 14 : 5;
      sender_paced = ($urandom_range(0, 3) != 0);
      receiver_paced = ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < 12; k++) begin
        if ($urandom_range(0, 9) < 7)
          write_entry($urandom_range(0, 7), $urandom_range(0, 7), rand_value());
        else
          run_power(rand_exponent(max_bits));
        sent++;
      end
      drain();
    end
    sender_paced = 1'b1;
    receiver_paced = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_dim(4'd3);
    hold_request = 3000;
    run_power(mmp_pkg::EXP_W'($urandom_range(1, 255)));
    write_entry(2, 2, rand_value());
    run_power(mmp_pkg::EXP_W'($urandom_range(1, 255)));
    write_entry(0, 1, rand_value());
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int unsigned k = 0; k < mmp_pkg::CELLS; k++) stored_matrix[k] = 0;
    dim_shadow = 4'd1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random(72);
    drain();
    if (failure_count == 0 && expected_entries.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
